// ===== sv/shaiu_pkg.sv =====
// Shared types, constants and SHA-512 functions for the instruction unit.
package shaiu_pkg;

    // Number of register stages from the input transfer to the output register.
    localparam int NUM_STAGES = 6;

    // Working words carried between the inner pipeline stages.
    localparam int NUM_WORDS = 10;

    // Operation selector codes.
    typedef enum logic [1:0] {
        FUNC_MSG1  = 2'd0,
        FUNC_MSG2  = 2'd1,
        FUNC_RNDS2 = 2'd2,
        FUNC_PASS  = 2'd3
    } func_t;

    // One input item.
    typedef struct packed {
        func_t       func;
        logic [63:0] dst_lane0;
        logic [63:0] dst_lane1;
        logic [63:0] dst_lane2;
        logic [63:0] dst_lane3;
        logic [63:0] src_lane0;
        logic [63:0] src_lane1;
        logic [63:0] src_lane2;
        logic [63:0] src_lane3;
        logic [63:0] wk_first;
        logic [63:0] wk_second;
    } in_t;

    // One result item.
    typedef struct packed {
        logic [63:0] res_lane0;
        logic [63:0] res_lane1;
        logic [63:0] res_lane2;
        logic [63:0] res_lane3;
    } out_t;

    // Contents of one inner pipeline stage.
    typedef struct packed {
        func_t                         func;
        logic [NUM_WORDS-1:0][63:0]    w;
    } stage_t;

    // Per-stage load enables and occupancy flags from the pipeline control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctl_t;

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        rotr64 = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] small_sig0(input logic [63:0] x);
        small_sig0 = rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sig1(input logic [63:0] x);
        small_sig1 = rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] big_sig0(input logic [63:0] x);
        big_sig0 = rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
    endfunction

    function automatic logic [63:0] big_sig1(input logic [63:0] x);
        big_sig1 = rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
    endfunction

    function automatic logic [63:0] choose(input logic [63:0] e, input logic [63:0] f,
                                           input logic [63:0] g);
        choose = (e & f) ^ (g & ~e);
    endfunction

    function automatic logic [63:0] majority(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== sv/shaiu_pipe_ctrl.sv =====
// Valid/ready control for the stage chain: occupancy bits and per-stage load enables.
module shaiu_pipe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  m_ready,
    output shaiu_pkg::pipe_ctl_t  ctl
);

    logic [shaiu_pkg::NUM_STAGES-1:0] valid_reg;
    logic [shaiu_pkg::NUM_STAGES-1:0] valid_next;
    logic [shaiu_pkg::NUM_STAGES:0]   ready;
    logic [shaiu_pkg::NUM_STAGES-1:0] prev_valid;

    // A stage can take a new item when it is empty or its item moves on this cycle.
    always_comb begin
        ready[shaiu_pkg::NUM_STAGES] = m_ready;
        for (int i = shaiu_pkg::NUM_STAGES - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    // Each stage receives the occupancy of the stage in front of it.
    always_comb begin
        prev_valid = {valid_reg[shaiu_pkg::NUM_STAGES-2:0], s_valid};
        for (int i = 0; i < shaiu_pkg::NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? prev_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready   = ready[0];
    assign ctl.load  = ready[shaiu_pkg::NUM_STAGES-1:0];
    assign ctl.valid = valid_reg;

`ifndef NO_ASSERTIONS
    // An empty first stage must always be able to take a transfer.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("first stage empty but input not ready");

    // An accepted input item occupies the first stage in the next cycle.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    // Without transfers on either side the number of items in flight is constant.
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_valid && s_ready) && !(valid_reg[shaiu_pkg::NUM_STAGES-1] && m_ready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg))))
        else $error("item lost or duplicated inside the pipeline");
`endif

endmodule

// ===== sv/sha512_instruction_unit_top.sv =====
// Top level of the SHA-512 message schedule and round instruction unit.
// An input passes st1 to st5 and the output register before m_valid offers its result.
// Throughput: one instruction per cycle unless m_ready stalls; each stage holds at most one
// 64-bit add chain. The round path's two chained 4-operand sums set the stage count.
// Backpressure stalls only the stages that are full; a bubble is filled at once.
// Reset (aresetn low, synchronous) empties every stage; payload registers keep their value.
module sha512_instruction_unit_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  shaiu_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output shaiu_pkg::out_t  m_data
);

    shaiu_pkg::pipe_ctl_t ctl;

    shaiu_pkg::stage_t st1_reg, st1_next;
    shaiu_pkg::stage_t st2_reg, st2_next;
    shaiu_pkg::stage_t st3_reg, st3_next;
    shaiu_pkg::stage_t st4_reg, st4_next;
    shaiu_pkg::stage_t st5_reg, st5_next;
    shaiu_pkg::out_t   out_reg, out_next;

    shaiu_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // Stage 1: message lanes for msg1 and the first half of msg2; round one's partial sums.
    always_comb begin
        st1_next      = '0;
        st1_next.func = s_data.func;
        case (s_data.func)
            shaiu_pkg::FUNC_MSG1: begin
                st1_next.w[0] = s_data.dst_lane0 + shaiu_pkg::small_sig0(s_data.dst_lane1);
                st1_next.w[1] = s_data.dst_lane1 + shaiu_pkg::small_sig0(s_data.dst_lane2);
                st1_next.w[2] = s_data.dst_lane2 + shaiu_pkg::small_sig0(s_data.dst_lane3);
                st1_next.w[3] = s_data.dst_lane3 + shaiu_pkg::small_sig0(s_data.src_lane0);
            end
            shaiu_pkg::FUNC_MSG2: begin
                st1_next.w[0] = s_data.dst_lane0 + shaiu_pkg::small_sig1(s_data.src_lane2);
                st1_next.w[1] = s_data.dst_lane1 + shaiu_pkg::small_sig1(s_data.src_lane3);
                st1_next.w[2] = s_data.dst_lane2;
                st1_next.w[3] = s_data.dst_lane3;
            end
            shaiu_pkg::FUNC_RNDS2: begin
                // h + wk + ch(e, f, g), Sigma1(e), t2, and g + wk for round two.
                st1_next.w[0] = s_data.dst_lane0 + s_data.wk_first
                              + shaiu_pkg::choose(s_data.src_lane1, s_data.src_lane0,
                                                  s_data.dst_lane1);
                st1_next.w[1] = shaiu_pkg::big_sig1(s_data.src_lane1);
                st1_next.w[2] = shaiu_pkg::big_sig0(s_data.src_lane3)
                              + shaiu_pkg::majority(s_data.src_lane3, s_data.src_lane2,
                                                    s_data.dst_lane3);
                st1_next.w[3] = s_data.dst_lane1 + s_data.wk_second;
                st1_next.w[4] = s_data.src_lane3;
                st1_next.w[5] = s_data.src_lane2;
                st1_next.w[6] = s_data.dst_lane2;
                st1_next.w[7] = s_data.dst_lane3;
                st1_next.w[8] = s_data.src_lane1;
                st1_next.w[9] = s_data.src_lane0;
            end
            default: begin
                st1_next.w[0] = s_data.dst_lane0;
                st1_next.w[1] = s_data.dst_lane1;
                st1_next.w[2] = s_data.dst_lane2;
                st1_next.w[3] = s_data.dst_lane3;
            end
        endcase
    end

    // Stage 2: second half of msg2; round one's t1.
    always_comb begin
        st2_next = st1_reg;
        case (st1_reg.func)
            shaiu_pkg::FUNC_MSG2: begin
                st2_next.w[2] = st1_reg.w[2] + shaiu_pkg::small_sig1(st1_reg.w[0]);
                st2_next.w[3] = st1_reg.w[3] + shaiu_pkg::small_sig1(st1_reg.w[1]);
            end
            shaiu_pkg::FUNC_RNDS2: begin
                st2_next.w[0] = st1_reg.w[0] + st1_reg.w[1];
            end
            default: begin
                st2_next = st1_reg;
            end
        endcase
    end

    // Stage 3: round one's new E (d + t1) and new A (t1 + t2).
    always_comb begin
        st3_next = st2_reg;
        if (st2_reg.func == shaiu_pkg::FUNC_RNDS2) begin
            st3_next.w[0] = st2_reg.w[6] + st2_reg.w[0];
            st3_next.w[1] = st2_reg.w[0] + st2_reg.w[2];
        end
    end

    // Stage 4: round two's partial sums from the new E and A.
    always_comb begin
        st4_next = st3_reg;
        if (st3_reg.func == shaiu_pkg::FUNC_RNDS2) begin
            st4_next.w[0] = st3_reg.w[3]
                          + shaiu_pkg::choose(st3_reg.w[0], st3_reg.w[8], st3_reg.w[9]);
            st4_next.w[1] = shaiu_pkg::big_sig1(st3_reg.w[0]);
            st4_next.w[2] = shaiu_pkg::big_sig0(st3_reg.w[1])
                          + shaiu_pkg::majority(st3_reg.w[1], st3_reg.w[4], st3_reg.w[5]);
            st4_next.w[3] = st3_reg.w[0];
            st4_next.w[4] = st3_reg.w[1];
        end
    end

    // Stage 5: round two's t1.
    always_comb begin
        st5_next = st4_reg;
        if (st4_reg.func == shaiu_pkg::FUNC_RNDS2) begin
            st5_next.w[0] = st4_reg.w[0] + st4_reg.w[1];
        end
    end

    // Stage 6: final lanes; rounds return F, E, B and A.
    always_comb begin
        if (st5_reg.func == shaiu_pkg::FUNC_RNDS2) begin
            out_next.res_lane0 = st5_reg.w[3];
            out_next.res_lane1 = st5_reg.w[7] + st5_reg.w[0];
            out_next.res_lane2 = st5_reg.w[4];
            out_next.res_lane3 = st5_reg.w[0] + st5_reg.w[2];
        end else begin
            out_next.res_lane0 = st5_reg.w[0];
            out_next.res_lane1 = st5_reg.w[1];
            out_next.res_lane2 = st5_reg.w[2];
            out_next.res_lane3 = st5_reg.w[3];
        end
    end

    // Payload registers load whenever their stage may advance.
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            st1_reg <= st1_next;
        end
        if (ctl.load[1]) begin
            st2_reg <= st2_next;
        end
        if (ctl.load[2]) begin
            st3_reg <= st3_next;
        end
        if (ctl.load[3]) begin
            st4_reg <= st4_next;
        end
        if (ctl.load[4]) begin
            st5_reg <= st5_next;
        end
        if (ctl.load[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = ctl.valid[shaiu_pkg::NUM_STAGES-1];
    assign m_data  = out_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the SHA-512 message schedule and round instruction unit.
`timescale 1ns / 100ps

module testbench;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1330;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    shaiu_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    shaiu_pkg::out_t m_data;

    shaiu_pkg::in_t instr_q[$];
    shaiu_pkg::out_t lane_results_q[$];
    int mismatch_count = 0;
    int idle_cycles = 0;

    // Sender burst control.
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall pattern control.
    int stall_mode = 0;
    int mode_left = 0;
    int run_left = 0;
    logic [1:0] phase = '0;

    sha512_instruction_unit_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] rot_right(input logic [63:0] x, input int unsigned n);
        logic [127:0] twice;
        twice = {x, x} >> n;
        return twice[63:0];
    endfunction

    function automatic logic [63:0] sched_sigma0(input logic [63:0] x);
        return rot_right(x, 1) ^ rot_right(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sched_sigma1(input logic [63:0] x);
        return rot_right(x, 19) ^ rot_right(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] round_sigma0(input logic [63:0] x);
        return rot_right(x, 28) ^ rot_right(x, 34) ^ rot_right(x, 39);
    endfunction

    function automatic logic [63:0] round_sigma1(input logic [63:0] x);
        return rot_right(x, 14) ^ rot_right(x, 18) ^ rot_right(x, 41);
    endfunction

    // Expected lanes of one instruction.
    function automatic shaiu_pkg::out_t compute_lanes(input shaiu_pkg::in_t item);
        shaiu_pkg::out_t r;
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
        logic [1:0][63:0] wk;
        r.res_lane0 = item.dst_lane0;
        r.res_lane1 = item.dst_lane1;
        r.res_lane2 = item.dst_lane2;
        r.res_lane3 = item.dst_lane3;
        case (item.func)
            shaiu_pkg::FUNC_MSG1: begin
                r.res_lane0 = item.dst_lane0 + sched_sigma0(item.dst_lane1);
                r.res_lane1 = item.dst_lane1 + sched_sigma0(item.dst_lane2);
                r.res_lane2 = item.dst_lane2 + sched_sigma0(item.dst_lane3);
                r.res_lane3 = item.dst_lane3 + sched_sigma0(item.src_lane0);
            end
            shaiu_pkg::FUNC_MSG2: begin
                r.res_lane0 = item.dst_lane0 + sched_sigma1(item.src_lane2);
                r.res_lane1 = item.dst_lane1 + sched_sigma1(item.src_lane3);
                r.res_lane2 = item.dst_lane2 + sched_sigma1(r.res_lane0);
                r.res_lane3 = item.dst_lane3 + sched_sigma1(r.res_lane1);
            end
            shaiu_pkg::FUNC_RNDS2: begin
                a = item.src_lane3;
                b = item.src_lane2;
                c = item.dst_lane3;
                d = item.dst_lane2;
                e = item.src_lane1;
                f = item.src_lane0;
                g = item.dst_lane1;
                h = item.dst_lane0;
                wk[0] = item.wk_first;
                wk[1] = item.wk_second;
                for (int k = 0; k < 2; k++) begin
                    t1 = h + round_sigma1(e) + ((e & f) ^ (g & ~e)) + wk[k];
                    t2 = round_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));
                    h = g;
                    g = f;
                    f = e;
                    e = d + t1;
                    d = c;
                    c = b;
                    b = a;
                    a = t1 + t2;
                end
                r.res_lane0 = f;
                r.res_lane1 = e;
                r.res_lane2 = b;
                r.res_lane3 = a;
            end
            default: begin
                // The unused selector passes the destination through.
            end
        endcase
        return r;
    endfunction

    // Random qword, biased toward the extremes and single-bit patterns.
    function automatic logic [63:0] random_qword();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Stimulus generation and end of run.
    initial begin : stimulus
        shaiu_pkg::in_t item;
        logic [63:0] pattern;
        for (int fn = 0; fn < 4; fn++) begin
            for (int p = 0; p < 5; p++) begin
                case (p)
                    0: pattern = '0;
                    1: pattern = '1;
                    2: pattern = 64'hAAAA_AAAA_AAAA_AAAA;
                    3: pattern = 64'h5555_5555_5555_5555;
                    default: pattern = 64'h8000_0000_0000_0001;
                endcase
                item.func = shaiu_pkg::func_t'(fn);
                item.dst_lane0 = pattern;
                item.dst_lane1 = ~pattern;
                item.dst_lane2 = pattern;
                item.dst_lane3 = ~pattern;
                item.src_lane0 = pattern;
                item.src_lane1 = ~pattern;
                item.src_lane2 = pattern;
                item.src_lane3 = ~pattern;
                item.wk_first = pattern;
                item.wk_second = ~pattern;
                instr_q.push_back(item);
            end
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: item.func = shaiu_pkg::FUNC_MSG1;
                3, 4, 5: item.func = shaiu_pkg::FUNC_MSG2;
                6, 7, 8: item.func = shaiu_pkg::FUNC_RNDS2;
                default: item.func = shaiu_pkg::FUNC_PASS;
            endcase
            item.dst_lane0 = random_qword();
            item.dst_lane1 = random_qword();
            item.dst_lane2 = random_qword();
            item.dst_lane3 = random_qword();
            item.src_lane0 = random_qword();
            item.src_lane1 = random_qword();
            item.src_lane2 = random_qword();
            item.src_lane3 = random_qword();
            item.wk_first = random_qword();
            item.wk_second = random_qword();
            instr_q.push_back(item);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (instr_q.size() != 0 || s_valid) @(posedge aclk);
        while (lane_results_q.size() != 0) @(posedge aclk);
        repeat (4 * shaiu_pkg::NUM_STAGES) @(posedge aclk);

        if (mismatch_count == 0 && lane_results_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Driver: sends instructions in bursts separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                lane_results_q.push_back(compute_lanes(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (instr_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= instr_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern switches between several modes over time.
    always @(posedge aclk) begin
        phase <= phase + 2'd1;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(40, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (phase == 2'd0);
            default: begin
                if (run_left == 0) begin
                    m_ready <= ~m_ready;
                    run_left <= $urandom_range(1, 20);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // Monitor: compares each result transfer with the oldest expected lanes.
    always @(posedge aclk) begin : monitor
        shaiu_pkg::out_t want;
        logic [3:0][63:0] want_v;
        logic [3:0][63:0] got_v;
        if (aresetn && m_valid && m_ready) begin
            if (lane_results_q.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("%0t: result with nothing expected: %h", $realtime, m_data);
                end
                mismatch_count++;
            end else begin
                want = lane_results_q.pop_front();
                want_v = want;
                got_v = m_data;
                // Lane 0 sits in the most significant qword of the packed struct.
                for (int k = 0; k < 4; k++) begin
                    if (want_v[3-k] !== got_v[3-k]) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: res_lane%0d expected %h actual %h",
                                     $realtime, k, want_v[3-k], got_v[3-k]);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
